@@ rtl/bekk_pkg.sv @@
// Shared types, constants and the micro-op program for the BEKK covariance filter.
package bekk_pkg;

    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int COEF_W    = 16;
    localparam int COEF_FRAC = 14;
    localparam int RET_INT   = 4;
    localparam int COV_INT   = 8;
    localparam int MID_FRAC  = 24;
    localparam int SUM_FRAC  = 38;
    localparam int V_W       = 32;
    localparam int VSPLIT    = 16;
    localparam int M_W       = 36;
    localparam int VV_W      = 50;
    localparam int VV_SHR    = 2 * MID_FRAC - SUM_FRAC;
    localparam int C_SHL     = SUM_FRAC - 2 * COEF_FRAC;
    localparam int STEP_W    = 6;

    localparam logic [STEP_W-1:0] LAST_STEP  = 6'd32;
    localparam logic [STEP_W-1:0] DRAIN_STEP = 6'd35;

    localparam logic [CFG_IDX_W-1:0] CFG_INTERCEPT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARCH      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GARCH     = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        X_A00, X_A01, X_A10, X_A11,
        X_B00, X_B01, X_B10, X_B11,
        X_C00, X_C01, X_C10, X_C11,
        X_V0_HI, X_V0_LO, X_V1_HI, X_V1_LO
    } xsel_t;

    typedef enum logic [3:0] {
        Y_R0, Y_R1,
        Y_H00, Y_H01, Y_H11,
        Y_V0, Y_V1,
        Y_M00, Y_M01, Y_M10, Y_M11,
        Y_C00, Y_C01, Y_C10, Y_C11
    } ysel_t;

    typedef enum logic [2:0] {
        SC_RAW,
        SC_SH16,
        SC_SH10,
        SC_RND_H,
        SC_VVR
    } scale_t;

    typedef enum logic [1:0] {
        BS_ZERO,
        BS_V,
        BS_VV,
        BS_N
    } bias_t;

    typedef enum logic [3:0] {
        D_NONE,
        D_V0, D_V1,
        D_M00, D_M01, D_M10, D_M11,
        D_VVR,
        D_N0, D_N1, D_N2
    } dest_t;

    typedef struct packed {
        xsel_t  xsel;
        ysel_t  ysel;
        scale_t sc;
        logic   clr;
        bias_t  bsel;
        dest_t  dest;
    } uop_t;

    typedef struct packed {
        logic   vld;
        scale_t sc;
        logic   clr;
        bias_t  bsel;
        dest_t  dest;
    } stage_t;

    function automatic uop_t mk_uop(xsel_t x, ysel_t y, scale_t sc, logic clr, bias_t b,
                                    dest_t d);
        uop_t u;
        u.xsel = x;
        u.ysel = y;
        u.sc   = sc;
        u.clr  = clr;
        u.bsel = b;
        u.dest = d;
        return u;
    endfunction

    // clr starts a new sum from the group's rounding bias; dest stores the finished sum
    function automatic uop_t prog_uop(logic [STEP_W-1:0] step);
        uop_t u;
        case (step)
            // v = A*r
            6'd0:  u = mk_uop(X_A00, Y_R0, SC_RAW, 1'b1, BS_V, D_NONE);
            6'd1:  u = mk_uop(X_A01, Y_R1, SC_RAW, 1'b0, BS_ZERO, D_V0);
            6'd2:  u = mk_uop(X_A10, Y_R0, SC_RAW, 1'b1, BS_V, D_NONE);
            6'd3:  u = mk_uop(X_A11, Y_R1, SC_RAW, 1'b0, BS_ZERO, D_V1);
            // M = B*H, each product rounded
            6'd4:  u = mk_uop(X_B00, Y_H00, SC_RND_H, 1'b1, BS_ZERO, D_NONE);
            6'd5:  u = mk_uop(X_B01, Y_H01, SC_RND_H, 1'b0, BS_ZERO, D_M00);
            6'd6:  u = mk_uop(X_B00, Y_H01, SC_RND_H, 1'b1, BS_ZERO, D_NONE);
            6'd7:  u = mk_uop(X_B01, Y_H11, SC_RND_H, 1'b0, BS_ZERO, D_M01);
            6'd8:  u = mk_uop(X_B10, Y_H00, SC_RND_H, 1'b1, BS_ZERO, D_NONE);
            6'd9:  u = mk_uop(X_B11, Y_H01, SC_RND_H, 1'b0, BS_ZERO, D_M10);
            6'd10: u = mk_uop(X_B10, Y_H01, SC_RND_H, 1'b1, BS_ZERO, D_NONE);
            6'd11: u = mk_uop(X_B11, Y_H11, SC_RND_H, 1'b0, BS_ZERO, D_M11);
            // entry 00
            6'd12: u = mk_uop(X_V0_HI, Y_V0, SC_SH16, 1'b1, BS_VV, D_NONE);
            6'd13: u = mk_uop(X_V0_LO, Y_V0, SC_RAW, 1'b0, BS_ZERO, D_VVR);
            6'd14: u = mk_uop(X_C00, Y_C00, SC_SH10, 1'b1, BS_N, D_NONE);
            6'd15: u = mk_uop(X_C01, Y_C01, SC_SH10, 1'b0, BS_ZERO, D_NONE);
            6'd16: u = mk_uop(X_B00, Y_M00, SC_RAW, 1'b0, BS_ZERO, D_NONE);
            6'd17: u = mk_uop(X_B01, Y_M01, SC_RAW, 1'b0, BS_ZERO, D_NONE);
            6'd18: u = mk_uop(X_A00, Y_R0, SC_VVR, 1'b0, BS_ZERO, D_N0);
            // entry 01
            6'd19: u = mk_uop(X_V1_HI, Y_V0, SC_SH16, 1'b1, BS_VV, D_NONE);
            6'd20: u = mk_uop(X_V1_LO, Y_V0, SC_RAW, 1'b0, BS_ZERO, D_VVR);
            6'd21: u = mk_uop(X_C00, Y_C10, SC_SH10, 1'b1, BS_N, D_NONE);
            6'd22: u = mk_uop(X_C01, Y_C11, SC_SH10, 1'b0, BS_ZERO, D_NONE);
            6'd23: u = mk_uop(X_B10, Y_M00, SC_RAW, 1'b0, BS_ZERO, D_NONE);
            6'd24: u = mk_uop(X_B11, Y_M01, SC_RAW, 1'b0, BS_ZERO, D_NONE);
            6'd25: u = mk_uop(X_A00, Y_R0, SC_VVR, 1'b0, BS_ZERO, D_N1);
            // entry 11
            6'd26: u = mk_uop(X_V1_HI, Y_V1, SC_SH16, 1'b1, BS_VV, D_NONE);
            6'd27: u = mk_uop(X_V1_LO, Y_V1, SC_RAW, 1'b0, BS_ZERO, D_VVR);
            6'd28: u = mk_uop(X_C10, Y_C10, SC_SH10, 1'b1, BS_N, D_NONE);
            6'd29: u = mk_uop(X_C11, Y_C11, SC_SH10, 1'b0, BS_ZERO, D_NONE);
            6'd30: u = mk_uop(X_B10, Y_M10, SC_RAW, 1'b0, BS_ZERO, D_NONE);
            6'd31: u = mk_uop(X_B11, Y_M11, SC_RAW, 1'b0, BS_ZERO, D_NONE);
            6'd32: u = mk_uop(X_A00, Y_R0, SC_VVR, 1'b0, BS_ZERO, D_N2);
            default: u = mk_uop(X_A00, Y_R0, SC_RAW, 1'b0, BS_ZERO, D_NONE);
        endcase
        return u;
    endfunction

endpackage

@@ rtl/bekk_covariance_recursion.sv @@
// Two-asset BEKK-GARCH(1,1) covariance filter, top level.
// Each accepted return pair produces one result: the covariance held before the
// update (upper triangle) and a flag that the update clipped an entry. Between acceptance
// and the next possible acceptance, while the output register is free, an item runs
// 33 micro-ops issued one per cycle through the single 17 x max(COV_BITS,36)
// multiply-accumulate unit, then the pipeline drain, a commit and a return to idle.
// The output register lets the next item run while a result waits.
// in_stall is high while an item is in flight. Configuration is taken at any time
// (cfg_ready is always high) and must only change while the block is idle.
module bekk_covariance_recursion #(
    parameter int RETURN_BITS = 16,
    parameter int COV_BITS    = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [RETURN_BITS-1:0]       return_first,
    input  logic signed [RETURN_BITS-1:0]       return_second,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [COV_BITS-1:0]          var_first,
    output logic signed [COV_BITS-1:0]          covar_cross,
    output logic signed [COV_BITS-1:0]          var_second,
    output logic                                saturated,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bekk_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bekk_pkg::CFG_W-1:0]          cfg_data
);
    import bekk_pkg::*;

    localparam int YW     = (COV_BITS > M_W) ? COV_BITS : M_W;
    localparam int XW     = COEF_W + 1;
    localparam int PW     = XW + YW;
    localparam int ACC_W  = (PW + 2 > 64) ? PW + 2 : 64;
    localparam int V_FROM = RETURN_BITS - RET_INT + COEF_FRAC;
    localparam int H_FROM = COV_BITS - COV_INT + COEF_FRAC;
    localparam int N_TO   = COV_BITS - COV_INT;
    localparam int V_SHR  = (V_FROM > MID_FRAC) ? V_FROM - MID_FRAC : 0;
    localparam int V_SHL  = (V_FROM < MID_FRAC) ? MID_FRAC - V_FROM : 0;
    localparam int H_SHR  = (H_FROM > MID_FRAC) ? H_FROM - MID_FRAC : 0;
    localparam int H_SHL  = (H_FROM < MID_FRAC) ? MID_FRAC - H_FROM : 0;
    localparam int N_SHR  = (SUM_FRAC > N_TO) ? SUM_FRAC - N_TO : 0;
    localparam int N_SHL  = (SUM_FRAC < N_TO) ? N_TO - SUM_FRAC : 0;

    localparam logic signed [ACC_W-1:0] ONE     = ACC_W'(1);
    localparam logic signed [ACC_W-1:0] V_BIAS  = (ONE << V_SHR) >>> 1;
    localparam logic signed [ACC_W-1:0] H_BIAS  = (ONE << H_SHR) >>> 1;
    localparam logic signed [ACC_W-1:0] N_BIAS  = (ONE << N_SHR) >>> 1;
    localparam logic signed [ACC_W-1:0] VV_BIAS = (ONE << VV_SHR) >>> 1;
    localparam logic signed [ACC_W-1:0] SAT_HI  = (ONE << (COV_BITS - 1)) - ONE;
    localparam logic signed [ACC_W-1:0] SAT_LO  = -(ONE << (COV_BITS - 1));
    localparam logic signed [COV_BITS-1:0] H_ONE = COV_BITS'(1) << N_TO;

    function automatic logic signed [XW-1:0] xcoef(logic [CFG_W-1:0] m, int k);
        logic signed [COEF_W-1:0] t;
        t = m[k*COEF_W +: COEF_W];
        return XW'(t);
    endfunction

    function automatic logic signed [YW-1:0] ycoef(logic [CFG_W-1:0] m, int k);
        logic signed [COEF_W-1:0] t;
        t = m[k*COEF_W +: COEF_W];
        return YW'(t);
    endfunction

    state_t                      state_reg, state_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic                        accept, out_free, issue, commit;
    uop_t                        uop;

    logic [CFG_W-1:0]            c_reg, a_reg, b_reg;
    logic signed [RETURN_BITS-1:0] r0_reg, r1_reg;
    logic signed [COV_BITS-1:0]  h00_reg, h01_reg, h11_reg;
    logic signed [COV_BITS-1:0]  n0_reg, n1_reg, n2_reg;
    logic signed [V_W-1:0]       v0_reg, v1_reg;
    logic signed [M_W-1:0]       m00_reg, m01_reg, m10_reg, m11_reg;
    logic signed [VV_W-1:0]      vvr_reg;
    logic                        sat_reg;

    logic signed [XW-1:0]        x_op;
    logic signed [YW-1:0]        y_op;
    logic signed [PW-1:0]        prod_full, prod_reg;
    logic signed [ACC_W-1:0]     p_ext, s_next, s_reg;
    logic signed [ACC_W-1:0]     bias_val, acc_next, acc_reg;
    logic signed [ACC_W-1:0]     v_full, vv_full, n_full, n_clip;
    logic                        n_over, n_store;
    stage_t                      ctl1_reg, ctl2_reg, ctl3_reg;

    logic                        out_valid_reg, saturated_reg;
    logic signed [COV_BITS-1:0]  var_first_reg, covar_cross_reg, var_second_reg;

    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;
    assign uop       = prog_uop(step_reg);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (step_reg == DRAIN_STEP)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        issue     = 1'b0;
        commit    = 1'b0;
        step_next = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                step_next = '0;
            end
            ST_RUN:
            begin
                issue     = (step_reg <= LAST_STEP);
                step_next = step_reg + STEP_W'(1);
            end
            ST_DONE:
            begin
                commit = out_free;
            end
            default:
            begin
                step_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            ctl1_reg  <= '0;
            ctl2_reg  <= '0;
            ctl3_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            ctl1_reg.vld  <= issue;
            ctl1_reg.sc   <= uop.sc;
            ctl1_reg.clr  <= uop.clr;
            ctl1_reg.bsel <= uop.bsel;
            ctl1_reg.dest <= uop.dest;
            ctl2_reg      <= ctl1_reg;
            ctl3_reg      <= ctl2_reg;
        end
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg <= '0;
            a_reg <= '0;
            b_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_INTERCEPT: c_reg <= cfg_data;
                CFG_ARCH:      a_reg <= cfg_data;
                CFG_GARCH:     b_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // operand select
    always_comb
    begin
        case (uop.xsel)
            X_A00:   x_op = xcoef(a_reg, 0);
            X_A01:   x_op = xcoef(a_reg, 1);
            X_A10:   x_op = xcoef(a_reg, 2);
            X_A11:   x_op = xcoef(a_reg, 3);
            X_B00:   x_op = xcoef(b_reg, 0);
            X_B01:   x_op = xcoef(b_reg, 1);
            X_B10:   x_op = xcoef(b_reg, 2);
            X_B11:   x_op = xcoef(b_reg, 3);
            X_C00:   x_op = xcoef(c_reg, 0);
            X_C01:   x_op = xcoef(c_reg, 1);
            X_C10:   x_op = xcoef(c_reg, 2);
            X_C11:   x_op = xcoef(c_reg, 3);
            X_V0_HI: x_op = {v0_reg[V_W-1], v0_reg[V_W-1:VSPLIT]};
            X_V0_LO: x_op = {1'b0, v0_reg[VSPLIT-1:0]};
            X_V1_HI: x_op = {v1_reg[V_W-1], v1_reg[V_W-1:VSPLIT]};
            X_V1_LO: x_op = {1'b0, v1_reg[VSPLIT-1:0]};
            default: x_op = '0;
        endcase
    end

    always_comb
    begin
        case (uop.ysel)
            Y_R0:    y_op = YW'(r0_reg);
            Y_R1:    y_op = YW'(r1_reg);
            Y_H00:   y_op = YW'(h00_reg);
            Y_H01:   y_op = YW'(h01_reg);
            Y_H11:   y_op = YW'(h11_reg);
            Y_V0:    y_op = YW'(v0_reg);
            Y_V1:    y_op = YW'(v1_reg);
            Y_M00:   y_op = YW'(m00_reg);
            Y_M01:   y_op = YW'(m01_reg);
            Y_M10:   y_op = YW'(m10_reg);
            Y_M11:   y_op = YW'(m11_reg);
            Y_C00:   y_op = ycoef(c_reg, 0);
            Y_C01:   y_op = ycoef(c_reg, 1);
            Y_C10:   y_op = ycoef(c_reg, 2);
            Y_C11:   y_op = ycoef(c_reg, 3);
            default: y_op = '0;
        endcase
    end

    assign prod_full = x_op * y_op;

    // product scaling
    always_comb
    begin
        p_ext = ACC_W'(prod_reg);
        case (ctl1_reg.sc)
            SC_RAW:   s_next = p_ext;
            SC_SH16:  s_next = p_ext <<< VSPLIT;
            SC_SH10:  s_next = p_ext <<< C_SHL;
            SC_RND_H: s_next = ((p_ext + H_BIAS) >>> H_SHR) <<< H_SHL;
            SC_VVR:   s_next = ACC_W'(vvr_reg);
            default:  s_next = p_ext;
        endcase
    end

    // accumulate
    always_comb
    begin
        case (ctl2_reg.bsel)
            BS_ZERO: bias_val = '0;
            BS_V:    bias_val = V_BIAS;
            BS_VV:   bias_val = VV_BIAS;
            BS_N:    bias_val = N_BIAS;
            default: bias_val = '0;
        endcase
        acc_next = (ctl2_reg.clr ? bias_val : acc_reg) + s_reg;
    end

    // store rescale and saturation
    always_comb
    begin
        v_full  = (acc_reg >>> V_SHR) <<< V_SHL;
        vv_full = acc_reg >>> VV_SHR;
        n_full  = (acc_reg >>> N_SHR) <<< N_SHL;
        n_over  = (n_full > SAT_HI) || (n_full < SAT_LO);
        if (n_full > SAT_HI)
            n_clip = SAT_HI;
        else if (n_full < SAT_LO)
            n_clip = SAT_LO;
        else
            n_clip = n_full;
    end

    assign n_store = ctl3_reg.vld &&
                     (ctl3_reg.dest == D_N0 || ctl3_reg.dest == D_N1 || ctl3_reg.dest == D_N2);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full;
        s_reg    <= s_next;
        if (ctl2_reg.vld)
            acc_reg <= acc_next;
        if (accept)
        begin
            r0_reg  <= return_first;
            r1_reg  <= return_second;
            sat_reg <= 1'b0;
        end
        else if (n_store && n_over)
        begin
            sat_reg <= 1'b1;
        end
        if (ctl3_reg.vld)
        begin
            case (ctl3_reg.dest)
                D_V0:    v0_reg  <= v_full[V_W-1:0];
                D_V1:    v1_reg  <= v_full[V_W-1:0];
                D_M00:   m00_reg <= acc_reg[M_W-1:0];
                D_M01:   m01_reg <= acc_reg[M_W-1:0];
                D_M10:   m10_reg <= acc_reg[M_W-1:0];
                D_M11:   m11_reg <= acc_reg[M_W-1:0];
                D_VVR:   vvr_reg <= vv_full[VV_W-1:0];
                D_N0:    n0_reg  <= n_clip[COV_BITS-1:0];
                D_N1:    n1_reg  <= n_clip[COV_BITS-1:0];
                D_N2:    n2_reg  <= n_clip[COV_BITS-1:0];
                default: ;
            endcase
        end
    end

    // covariance state, committed on the same edge that hands the old value to the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h00_reg <= H_ONE;
            h01_reg <= '0;
            h11_reg <= H_ONE;
        end
        else if (commit)
        begin
            h00_reg <= n0_reg;
            h01_reg <= n1_reg;
            h11_reg <= n2_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (commit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            var_first_reg   <= h00_reg;
            covar_cross_reg <= h01_reg;
            var_second_reg  <= h11_reg;
            saturated_reg   <= sat_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign var_first   = var_first_reg;
    assign covar_cross = covar_cross_reg;
    assign var_second  = var_second_reg;
    assign saturated   = saturated_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (in_stall && state_reg == ST_RUN && step_reg == '0))
        else $error("transfer did not start a run at step zero");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside commit");

    a_last_store: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl3_reg.vld && ctl3_reg.dest == D_N2) |-> (state_reg == ST_RUN && step_reg == DRAIN_STEP))
        else $error("final entry store out of step with sequencer");

    a_issue_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        ctl1_reg.vld |-> (state_reg == ST_RUN))
        else $error("micro-op in flight outside run");

    a_hold_in_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid && out_stall) |=>
        (state_reg == ST_DONE && $stable(var_first) && $stable(h00_reg)))
        else $error("commit while output still occupied");

endmodule

@@ dv/bekk_covariance_recursion_tb.sv @@
// Self-checking testbench for the BEKK covariance filter: bit-exact predictor, random stalls.
`timescale 1ns / 100ps

module bekk_covariance_recursion_tb;

    import bekk_pkg::*;

    localparam int RET_BITS = 16;
    localparam int COV_BITS = 32;
    localparam int RET_FRAC = RET_BITS - RET_INT;
    localparam int COV_FRAC = COV_BITS - COV_INT;
    localparam longint COV_MAX = (longint'(1) <<< (COV_BITS - 1)) - 1;
    localparam longint COV_MIN = -(longint'(1) <<< (COV_BITS - 1));
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int RANDOM_PHASES = 9;
    localparam int PAIRS_PER_PHASE = 150;

    typedef struct {
        logic signed [RET_BITS-1:0] ret0;
        logic signed [RET_BITS-1:0] ret1;
    } return_pair_t;

    typedef struct {
        logic signed [COV_BITS-1:0] var_first;
        logic signed [COV_BITS-1:0] covar_cross;
        logic signed [COV_BITS-1:0] var_second;
        logic                       saturated;
    } cov_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic signed [RET_BITS-1:0] return_first = '0;
    logic signed [RET_BITS-1:0] return_second = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [COV_BITS-1:0] var_first;
    logic signed [COV_BITS-1:0] covar_cross;
    logic signed [COV_BITS-1:0] var_second;
    logic                       saturated;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]           cfg_data = '0;

    // predictor copy of configuration and covariance
    logic [CFG_W-1:0] mdl_intercept;
    logic [CFG_W-1:0] mdl_arch;
    logic [CFG_W-1:0] mdl_garch;
    longint           mdl_cov [3];

    return_pair_t pending_returns [$];
    cov_result_t  expected_cov [$];
    return_pair_t next_pair;
    cov_result_t  want;

    logic in_fire = 1'b0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   queued_count = 0;
    int   accepted_count = 0;
    int   checked_count = 0;
    int   clip_count = 0;
    int   setting_count = 0;
    int   mismatch_count = 0;

    bekk_covariance_recursion #(
        .RETURN_BITS (RET_BITS),
        .COV_BITS    (COV_BITS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .return_first  (return_first),
        .return_second (return_second),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .var_first     (var_first),
        .covar_cross   (covar_cross),
        .var_second    (var_second),
        .saturated     (saturated),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic longint round_shift(longint x, int s);
        return (x + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint coef(logic [CFG_W-1:0] mat, int k);
        logic signed [COEF_W-1:0] e;
        e = mat[COEF_W*k +: COEF_W];
        return longint'(e);
    endfunction

    function automatic logic [CFG_W-1:0] pack4(logic [15:0] e00, logic [15:0] e01,
                                               logic [15:0] e10, logic [15:0] e11);
        return {e11, e10, e01, e00};
    endfunction

    // one BEKK step: emits the held covariance and advances it
    function automatic cov_result_t advance_covariance(logic signed [RET_BITS-1:0] ret0,
                                                       logic signed [RET_BITS-1:0] ret1);
        cov_result_t res;
        longint c [2][2];
        longint a [2][2];
        longint b [2][2];
        longint h [2][2];
        longint m [2][2];
        longint v [2];
        longint r [2];
        longint nxt [3];
        longint t;
        int p;
        int q;
        logic clip;
        clip = 1'b0;
        r[0] = longint'(ret0);
        r[1] = longint'(ret1);
        for (int k = 0; k < 4; k++)
        begin
            c[k / 2][k % 2] = coef(mdl_intercept, k);
            a[k / 2][k % 2] = coef(mdl_arch, k);
            b[k / 2][k % 2] = coef(mdl_garch, k);
        end
        h[0][0] = mdl_cov[0];
        h[0][1] = mdl_cov[1];
        h[1][0] = mdl_cov[1];
        h[1][1] = mdl_cov[2];
        for (int i = 0; i < 2; i++)
        begin
            v[i] = round_shift(a[i][0] * r[0] + a[i][1] * r[1], COEF_FRAC + RET_FRAC - MID_FRAC);
            for (int k = 0; k < 2; k++)
                m[i][k] = round_shift(b[i][0] * h[0][k], COEF_FRAC + COV_FRAC - MID_FRAC)
                        + round_shift(b[i][1] * h[1][k], COEF_FRAC + COV_FRAC - MID_FRAC);
        end
        for (int e = 0; e < 3; e++)
        begin
            p = (e == 2) ? 1 : 0;
            q = (e == 0) ? 0 : 1;
            t = ((c[p][0] * c[q][0] + c[p][1] * c[q][1]) <<< (SUM_FRAC - 2 * COEF_FRAC))
              + round_shift(v[p] * v[q], 2 * MID_FRAC - SUM_FRAC)
              + m[p][0] * b[q][0] + m[p][1] * b[q][1];
            nxt[e] = round_shift(t, SUM_FRAC - COV_FRAC);
            if (nxt[e] > COV_MAX)
            begin
                nxt[e] = COV_MAX;
                clip = 1'b1;
            end
            if (nxt[e] < COV_MIN)
            begin
                nxt[e] = COV_MIN;
                clip = 1'b1;
            end
        end
        res.var_first   = COV_BITS'(mdl_cov[0]);
        res.covar_cross = COV_BITS'(mdl_cov[1]);
        res.var_second  = COV_BITS'(mdl_cov[2]);
        res.saturated   = clip;
        mdl_cov = nxt;
        return res;
    endfunction

    function automatic void check_field(string name, logic signed [63:0] exp_val,
                                        logic signed [63:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            mismatch_count++;
        end
    endfunction

    // monitor and predictor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_fire       <= 1'b0;
            mdl_intercept = '0;
            mdl_arch      = '0;
            mdl_garch     = '0;
            mdl_cov[0]    = longint'(1) <<< COV_FRAC;
            mdl_cov[1]    = 0;
            mdl_cov[2]    = longint'(1) <<< COV_FRAC;
        end
        else
        begin
            in_fire <= in_valid && !in_stall;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_INTERCEPT: mdl_intercept = cfg_data;
                    CFG_ARCH:      mdl_arch = cfg_data;
                    CFG_GARCH:     mdl_garch = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_cov.size() == 0)
                begin
                    $error("result transfer with no expected covariance pending");
                    mismatch_count++;
                end
                else
                begin
                    want = expected_cov.pop_front();
                    check_field("var_first", 64'(want.var_first), 64'(var_first));
                    check_field("covar_cross", 64'(want.covar_cross), 64'(covar_cross));
                    check_field("var_second", 64'(want.var_second), 64'(var_second));
                    check_field("saturated", 64'(want.saturated), 64'(saturated));
                    checked_count++;
                end
            end
            if (in_valid && !in_stall)
            begin
                want = advance_covariance(return_first, return_second);
                if (want.saturated)
                    clip_count++;
                expected_cov = {expected_cov, want};
                accepted_count++;
            end
        end
    end

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
            if (!in_valid || in_fire)
            begin
                if (pending_returns.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_pair = pending_returns.pop_front();
                    in_valid      <= 1'b1;
                    return_first  <= next_pair.ret0;
                    return_second <= next_pair.ret1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_matrices(input logic [CFG_W-1:0] cm, input logic [CFG_W-1:0] am,
                                input logic [CFG_W-1:0] bm);
        write_reg(CFG_INTERCEPT, cm);
        write_reg(CFG_ARCH, am);
        write_reg(CFG_GARCH, bm);
        setting_count++;
    endtask

    task automatic queue_pair(input logic signed [RET_BITS-1:0] r0,
                              input logic signed [RET_BITS-1:0] r1);
        return_pair_t pr;
        pr.ret0 = r0;
        pr.ret1 = r1;
        pending_returns = {pending_returns, pr};
        queued_count++;
    endtask

    task automatic wait_drained();
        while (accepted_count != queued_count || checked_count != accepted_count)
            @(negedge clk);
    endtask

    function automatic logic [15:0] near_coef(int unsigned lim);
        return 16'($signed($urandom_range(2 * lim)) - $signed(lim));
    endfunction

    function automatic logic [15:0] corner_coef();
        case ($urandom_range(5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return 16'h4000;
            default: return 16'hC000;
        endcase
    endfunction

    function automatic logic signed [RET_BITS-1:0] random_return();
        case ($urandom_range(9))
            0: return ($urandom_range(1) != 0) ? 16'sh7FFF : 16'sh8000;
            1, 2, 3, 4: return RET_BITS'($urandom);
            default: return near_coef(16'h0800);
        endcase
    endfunction

    task automatic run_random_phase(input int mode, input int count);
        case (mode)
            0: set_matrices(pack4(near_coef(16'h1000), near_coef(16'h1000),
                                  near_coef(16'h1000), near_coef(16'h1000)),
                            pack4(near_coef(16'h2000), near_coef(16'h2000),
                                  near_coef(16'h2000), near_coef(16'h2000)),
                            pack4(16'($urandom_range(16'h3E00, 16'h3000)), near_coef(16'h0400),
                                  near_coef(16'h0400), 16'($urandom_range(16'h3E00, 16'h3000))));
            1: set_matrices({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
            default: set_matrices(pack4(corner_coef(), corner_coef(), corner_coef(), corner_coef()),
                                  pack4(corner_coef(), corner_coef(), corner_coef(), corner_coef()),
                                  pack4(corner_coef(), corner_coef(), corner_coef(), corner_coef()));
        endcase
        if ($urandom_range(1) != 0)
            write_reg(CFG_UNUSED, {$urandom, $urandom});
        for (int n = 0; n < count; n++)
            queue_pair(random_return(), random_return());
        wait_drained();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 14;
        recv_idle_pct = 79;

        // reset configuration: all matrices zero
        queue_pair(16'sh7FFF, 16'sh8000);
        queue_pair(16'sh1000, -16'sh1000);
        queue_pair(16'sh0000, 16'sh0000);
        wait_drained();

        // stable setting, extreme and small returns
        set_matrices(pack4(16'h2000, 16'h0000, 16'h0800, 16'h2000),
                     pack4(16'h1333, 16'h0000, 16'h0000, 16'h1333),
                     pack4(16'h3CCC, 16'h0000, 16'h0000, 16'h3CCC));
        queue_pair(16'sh7FFF, 16'sh7FFF);
        queue_pair(16'sh8000, 16'sh8000);
        queue_pair(16'sh7FFF, 16'sh8000);
        queue_pair(16'sh8000, 16'sh7FFF);
        queue_pair(16'sh0000, 16'sh0000);
        queue_pair(16'sh0001, -16'sh0001);
        queue_pair(-16'sh0001, 16'sh0001);
        queue_pair(16'sh1000, 16'sh0800);
        wait_drained();

        // clipping toward the upper bound
        set_matrices(64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF);
        queue_pair(16'sh7FFF, 16'sh7FFF);
        queue_pair(16'sh7FFF, 16'sh7FFF);
        queue_pair(16'sh8000, 16'sh7FFF);
        queue_pair(16'sh0000, 16'sh0000);
        wait_drained();

        // clipping toward the lower bound; unused index must be ignored
        set_matrices(64'hFFFF_FFFF_FFFF_FFFF, pack4(16'h8000, 16'h0000, 16'h0000, 16'h7FFF),
                     64'h8000_8000_8000_8000);
        write_reg(CFG_UNUSED, 64'hA5A5_5A5A_FFFF_0000);
        queue_pair(16'sh7FFF, 16'sh7FFF);
        queue_pair(16'sh8000, 16'sh8000);
        queue_pair(16'sh7FFF, 16'sh8000);
        queue_pair(16'sh8000, 16'sh7FFF);
        wait_drained();

        set_matrices(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_pair(16'sh7FFF, 16'sh8000);
        queue_pair(16'shFFFF, 16'shFFFF);
        queue_pair(16'sh5555, 16'shAAAA);
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph < RANDOM_PHASES / 3)
            begin
                send_idle_pct = 14;
                recv_idle_pct = 79;
            end
            else if (ph < 2 * RANDOM_PHASES / 3)
            begin
                send_idle_pct = 79;
                recv_idle_pct = 14;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_random_phase(ph % 3, PAIRS_PER_PHASE);
        end

        wait_drained();
        repeat (40) @(negedge clk);
        $display("Checked %0d covariance updates over %0d matrix settings, %0d of them clipped.",
                 checked_count, setting_count, clip_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Timed out with %0d covariance results outstanding", expected_cov.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ bekk_covariance_recursion.f @@
rtl/bekk_pkg.sv
rtl/bekk_covariance_recursion.sv
dv/bekk_covariance_recursion_tb.sv
